@@ rtl/core/sbt_pkg.sv @@
// shared types, constants and helper functions for the source byte tokenizer
package sbt_pkg;

	localparam int MaxCommentDepth = 15;
	localparam int KeywordBytes    = 8;
	localparam int CounterBits     = 16;
	localparam int QueueDepth      = 4;

	localparam logic [6:0] K_IDENT = 7'd0;
	localparam logic [6:0] K_INT   = 7'd19;
	localparam logic [6:0] K_FLT   = 7'd20;
	localparam logic [6:0] K_CHR   = 7'd21;
	localparam logic [6:0] K_STR   = 7'd22;
	localparam logic [6:0] K_NL    = 7'd23;
	localparam logic [6:0] K_LCMT  = 7'd24;
	localparam logic [6:0] K_BCMT  = 7'd25;
	localparam logic [6:0] K_NONE  = 7'd127;

	localparam logic [2:0] E_NONE    = 3'd0;
	localparam logic [2:0] E_UNKNOWN = 3'd1;
	localparam logic [2:0] E_UTF8    = 3'd2;
	localparam logic [2:0] E_ESCAPE  = 3'd3;
	localparam logic [2:0] E_UNCLOSED = 3'd4;

	typedef enum logic [4:0] {
		S_IDLE, S_IDENT, S_ZERO, S_DEC, S_FRAC, S_EXPI0, S_EXPI, S_EXPF0, S_EXPF,
		S_HEX, S_BIN, S_OCT, S_DECP, S_STR, S_CHR0, S_CHRU, S_CHRE, S_CHRC,
		S_OPP, S_LCMT, S_BCMT, S_BSTAR, S_BSLASH
	} scan_t;

	// one token descriptor leaving the scanner
	typedef struct packed {
		logic [6:0]  kind;
		logic [15:0] length;
		logic [15:0] line;
		logic [15:0] column;
		logic [2:0]  err;
		logic        last;
	} token_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [6:0] single_kind(input logic [7:0] c);
		logic [6:0] k;
		case (c)
			"(": k = 7'd26; ")": k = 7'd27; "&": k = 7'd28; "!": k = 7'd31;
			"%": k = 7'd33; ".": k = 7'd35; ",": k = 7'd36; "+": k = 7'd37;
			"-": k = 7'd40; "*": k = 7'd43; "=": k = 7'd45; "<": k = 7'd47;
			">": k = 7'd50; ":": k = 7'd53; "/": k = 7'd54; "{": k = 7'd56;
			"[": k = 7'd57; "]": k = 7'd58; "?": k = 7'd59; "^": k = 7'd60;
			"}": k = 7'd62; "|": k = 7'd63; "~": k = 7'd66;
			default: k = K_NONE;
		endcase
		return k;
	endfunction

	function automatic logic pairable(input logic [7:0] c);
		logic r;
		case (c)
			"&", "!", "%", "+", "-", "*", "=", "<", ">", "/", "^", "|": r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [6:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
		logic [6:0] k;
		case ({p, c})
			{"&", "&"}: k = 7'd29; {"&", "="}: k = 7'd30; {"!", "="}: k = 7'd32;
			{"%", "="}: k = 7'd34; {"+", "+"}: k = 7'd38; {"+", "="}: k = 7'd39;
			{"-", "-"}: k = 7'd41; {"-", "="}: k = 7'd42; {"*", "="}: k = 7'd44;
			{"=", "="}: k = 7'd46; {"<", "="}: k = 7'd48; {"<", "<"}: k = 7'd49;
			{">", "="}: k = 7'd51; {">", ">"}: k = 7'd52; {"/", "="}: k = 7'd55;
			{"^", "="}: k = 7'd61; {"|", "|"}: k = 7'd64; {"|", "="}: k = 7'd65;
			default: k = K_NONE;
		endcase
		return k;
	endfunction

	// keyword lookup over a zero-padded window of the first bytes
	function automatic logic [6:0] kw_kind(input logic [63:0] w, input logic [15:0] len);
		logic [6:0] k;
		k = K_IDENT;
		case (len)
			16'd2: case (w[15:0])
				"fi": k = 7'd1; "fe": k = 7'd2; "ni": k = 7'd13; "to": k = 7'd14;
				default: k = K_IDENT;
			endcase
			16'd3: if (w[23:0] == "rof") k = 7'd4;
			16'd4: case (w[31:0])
				"esle": k = 7'd3; "cnuf": k = 7'd7; "laed": k = 7'd10;
				"esac": k = 7'd11; "epyt": k = 7'd12;
				default: k = K_IDENT;
			endcase
			16'd5: case (w[39:0])
				"kaerb": k = 7'd5; "rorre": k = 7'd9;
				default: k = K_IDENT;
			endcase
			16'd6: case (w[47:0])
				"nruter": k = 7'd8; "eludom": k = 7'd16; "hctiws": k = 7'd18;
				default: k = K_IDENT;
			endcase
			16'd7: case (w[55:0])
				"edulcni": k = 7'd15; "tluafed": k = 7'd17;
				default: k = K_IDENT;
			endcase
			16'd8: if (w == "eunitnoc") k = 7'd6;
			default: k = K_IDENT;
		endcase
		return k;
	endfunction

endpackage

@@ rtl/core/sbt_scan.sv @@
// front part: scanner state machine, classifies bytes into up to three descriptors
module sbt_scan #(
	parameter int MAX_COMMENT_DEPTH = sbt_pkg::MaxCommentDepth,
	parameter int KEYWORD_BYTES     = sbt_pkg::KeywordBytes,
	parameter int COUNTER_BITS      = sbt_pkg::CounterBits
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        source_byte,
	input  logic              end_of_input,
	output logic [1:0]        tok_n,
	output sbt_pkg::token_t   tok0,
	output sbt_pkg::token_t   tok1,
	output sbt_pkg::token_t   tok2
);
	import sbt_pkg::*;

	localparam int DW = $clog2(MAX_COMMENT_DEPTH + 1);
	localparam logic [COUNTER_BITS-1:0] CMAX = '1;
	localparam logic [DW-1:0] DMAX = DW'(MAX_COMMENT_DEPTH);

	scan_t                    state_q;
	logic [8*KEYWORD_BYTES-1:0] win_q;
	logic [15:0]              len_q;
	logic [COUNTER_BITS-1:0]  line_q, col_q, bline_q, bcol_q;
	logic [DW-1:0]            depth_q;
	logic [7:0]               pend_q;
	logic [1:0]               utf_q;

	scan_t                    st;
	logic [8*KEYWORD_BYTES-1:0] win;
	logic [15:0]              len;
	logic [COUNTER_BITS-1:0]  line, bline, bcol;
	logic [DW-1:0]            depth;
	logic [7:0]               pend;
	logic [1:0]               utf;
	logic                     nl, again;
	logic [1:0]               n;
	token_t                   t [3];
	logic [6:0]               k;

	function automatic logic [15:0] clip(input logic [COUNTER_BITS-1:0] v);
		logic [15:0] r;
		if (COUNTER_BITS > 16 && (v >> 16) != 0) r = 16'hFFFF;
		else r = 16'(v);
		return r;
	endfunction

	always_comb begin
		st = state_q; win = win_q; len = len_q; line = line_q; bline = bline_q;
		bcol = bcol_q; depth = depth_q; pend = pend_q; utf = utf_q;
		nl = 1'b0; again = 1'b0; n = 2'd0; k = K_NONE;
		for (int i = 0; i < 3; i++) t[i] = '0;
		for (int pass = 0; pass < 2; pass++) begin
			if (pass == 0 || again) begin
				again = 1'b0;
				k = K_NONE;
				if (pass == 1) st = S_IDLE;
				case (st)
					S_IDENT: if (is_alpha(source_byte) || is_digit(source_byte)) begin
						if (len < 16'(KEYWORD_BYTES)) win[8*len[$clog2(KEYWORD_BYTES)-1:0] +: 8] = source_byte;
						if (len != 16'hFFFF) len = len + 16'd1;
					end else begin
						t[n] = '{kw_kind(64'(win), len), len, clip(bline), clip(bcol), E_NONE, 1'b0};
						n = n + 2'd1; st = S_IDLE; again = 1'b1;
					end
					default: ;
				endcase
				if (st != S_IDENT && st != S_IDLE || (st == S_IDLE && !again && pass == 1)
					|| (st == S_IDLE && state_q == S_IDLE && pass == 0)) begin
					logic tk, fin;
					logic [6:0] fk;
					logic [2:0] fe;
					tk = 1'b0; fin = 1'b0; fk = K_INT; fe = E_NONE;
					case (st)
						S_ZERO: begin
							tk = 1'b1;
							if (source_byte == "x" || source_byte == "X") st = S_HEX;
							else if (source_byte == "b" || source_byte == "B") st = S_BIN;
							else if (source_byte == "o" || source_byte == "O") st = S_OCT;
							else if (source_byte == "d" || source_byte == "D") st = S_DECP;
							else begin tk = 1'b0; fin = 1'b1; end
						end
						S_DEC: begin
							tk = 1'b1;
							if (source_byte == ".") st = S_FRAC;
							else if (source_byte == "e" || source_byte == "E") st = S_EXPI0;
							else if (!is_digit(source_byte)) begin tk = 1'b0; fin = 1'b1; end
						end
						S_FRAC: begin
							tk = 1'b1; fk = K_FLT;
							if (source_byte == "e" || source_byte == "E") st = S_EXPF0;
							else if (!is_digit(source_byte)) begin tk = 1'b0; fin = 1'b1; end
						end
						S_EXPI0, S_EXPF0: begin
							fk = (st == S_EXPI0) ? K_INT : K_FLT;
							if (source_byte == "+" || source_byte == "-" || is_digit(source_byte)) begin
								tk = 1'b1; st = (st == S_EXPI0) ? S_EXPI : S_EXPF;
							end else fin = 1'b1;
						end
						S_EXPI, S_EXPF: begin
							fk = (st == S_EXPI) ? K_INT : K_FLT;
							if (is_digit(source_byte)) tk = 1'b1; else fin = 1'b1;
						end
						S_HEX: if (is_hex(source_byte)) tk = 1'b1; else fin = 1'b1;
						S_BIN: if (source_byte == "0" || source_byte == "1") tk = 1'b1; else fin = 1'b1;
						S_OCT: if (source_byte >= "0" && source_byte <= "7") tk = 1'b1; else fin = 1'b1;
						S_DECP: if (is_digit(source_byte)) tk = 1'b1; else fin = 1'b1;
						S_STR: begin
							tk = 1'b1;
							if (source_byte == "\"") begin k = K_STR; st = S_IDLE; end
						end
						S_CHR0: begin
							fk = K_CHR;
							if (source_byte == "\\") begin tk = 1'b1; st = S_CHRE; end
							else if (source_byte < 8'h80) begin tk = 1'b1; st = S_CHRC; end
							else if ((source_byte & 8'hE0) == 8'hC0) begin tk = 1'b1; utf = 2'd1; st = S_CHRU; end
							else if ((source_byte & 8'hF0) == 8'hE0) begin tk = 1'b1; utf = 2'd2; st = S_CHRU; end
							else if ((source_byte & 8'hF8) == 8'hF0) begin tk = 1'b1; utf = 2'd3; st = S_CHRU; end
							else begin fin = 1'b1; fe = E_UTF8; end
						end
						S_CHRU: begin
							tk = 1'b1;
							if (utf != 2'd0) utf = utf - 2'd1;
							if (utf == 2'd0) st = S_CHRC;
						end
						S_CHRE: begin
							fk = K_CHR;
							case (source_byte)
								"a", "b", "f", "n", "r", "v", "\\", "'", "\"", "0": begin
									tk = 1'b1; st = S_CHRC;
								end
								default: begin fin = 1'b1; fe = E_ESCAPE; end
							endcase
						end
						S_CHRC: begin
							fk = K_CHR;
							if (source_byte == "'") begin tk = 1'b1; k = K_CHR; st = S_IDLE; end
							else begin fin = 1'b1; fe = E_UNCLOSED; end
						end
						S_OPP: begin
							if (pend == "/" && source_byte == "/") begin tk = 1'b1; st = S_LCMT; end
							else if (pend == "/" && source_byte == "*") begin
								tk = 1'b1; depth = '0; st = S_BCMT;
							end else if (pair_kind(pend, source_byte) != K_NONE) begin
								tk = 1'b1; k = pair_kind(pend, source_byte); st = S_IDLE;
							end else begin
								fin = 1'b1;
								fk = (single_kind(pend) == K_NONE) ? K_IDENT : single_kind(pend);
								fe = (single_kind(pend) == K_NONE) ? E_UNKNOWN : E_NONE;
							end
						end
						S_LCMT: begin
							fk = K_LCMT;
							if (source_byte == "\r" || source_byte == "\n") fin = 1'b1; else tk = 1'b1;
						end
						S_BCMT, S_BSTAR, S_BSLASH: begin
							tk = 1'b1;
							if (st == S_BSTAR && source_byte == "/") begin
								if (depth == '0) begin k = K_BCMT; st = S_IDLE; end
								else begin depth = depth - 1'b1; st = S_BSLASH; end
							end else if (st == S_BSLASH && source_byte == "*") begin
								if (depth < DMAX) depth = depth + 1'b1;
								st = S_BCMT;
							end else if (source_byte == "*") st = S_BSTAR;
							else if (source_byte == "/") st = S_BSLASH;
							else st = S_BCMT;
						end
						default: begin
							// idle: start a token
							if (source_byte != " " && source_byte != "\t") begin
								bline = line; bcol = col_q; len = 16'd1;
								win = '0; win[7:0] = source_byte;
								if (source_byte == "\r" || source_byte == "\n") begin
									k = K_NL;
									if (line != CMAX) line = line + 1'b1;
									nl = 1'b1;
								end else if (is_alpha(source_byte)) st = S_IDENT;
								else if (source_byte == "0") st = S_ZERO;
								else if (is_digit(source_byte)) st = S_DEC;
								else if (source_byte == "\"") st = S_STR;
								else if (source_byte == "'") st = S_CHR0;
								else if (pairable(source_byte)) begin pend = source_byte; st = S_OPP; end
								else if (single_kind(source_byte) != K_NONE) k = single_kind(source_byte);
								else begin
									t[n] = '{K_IDENT, len, clip(bline), clip(bcol), E_UNKNOWN, 1'b0};
									n = n + 2'd1;
								end
							end
						end
					endcase
					if (tk) begin
						if (len < 16'(KEYWORD_BYTES)) win[8*len[$clog2(KEYWORD_BYTES)-1:0] +: 8] = source_byte;
						if (len != 16'hFFFF) len = len + 16'd1;
					end
					if (k != K_NONE) begin
						t[n] = '{k, len, clip(bline), clip(bcol), E_NONE, 1'b0};
						n = n + 2'd1;
					end
					if (fin) begin
						t[n] = '{fk, len, clip(bline), clip(bcol), fe, 1'b0};
						n = n + 2'd1; st = S_IDLE; again = 1'b1;
					end
				end
			end
		end
		if (end_of_input) begin
			case (st)
				S_IDLE: k = K_NONE;
				S_IDENT: begin k = kw_kind(64'(win), len); end
				S_FRAC, S_EXPF0, S_EXPF: k = K_FLT;
				S_STR: k = K_STR;
				S_CHR0, S_CHRU, S_CHRE, S_CHRC: k = K_CHR;
				S_OPP: k = (single_kind(pend) == K_NONE) ? K_IDENT : single_kind(pend);
				S_LCMT: k = K_LCMT;
				S_BCMT, S_BSTAR, S_BSLASH: k = K_BCMT;
				default: k = K_INT;
			endcase
			if (st != S_IDLE) begin
				t[n] = '{k, len, clip(bline), clip(bcol),
					(st == S_CHR0 || st == S_CHRU || st == S_CHRE || st == S_CHRC) ? E_UNCLOSED :
					(st == S_OPP && single_kind(pend) == K_NONE) ? E_UNKNOWN : E_NONE, 1'b0};
				n = n + 2'd1;
			end
			st = S_IDLE; depth = '0; pend = '0; utf = '0;
		end
		if (n != 2'd0) t[n - 2'd1].last = 1'b1;
	end

	assign tok_n = n;
	assign tok0 = t[0];
	assign tok1 = t[1];
	assign tok2 = t[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; win_q <= '0; len_q <= '0;
			line_q <= COUNTER_BITS'(1); col_q <= COUNTER_BITS'(1);
			bline_q <= COUNTER_BITS'(1); bcol_q <= COUNTER_BITS'(1);
			depth_q <= '0; pend_q <= '0; utf_q <= '0;
		end else if (take) begin
			state_q <= st; win_q <= win; len_q <= len; line_q <= line;
			bline_q <= bline; bcol_q <= bcol; depth_q <= depth; pend_q <= pend; utf_q <= utf;
			if (nl) col_q <= COUNTER_BITS'(1);
			else if (col_q != CMAX) col_q <= col_q + 1'b1;
		end
	end

`ifndef SYNTH
	a_depth: assert property (@(posedge clk) disable iff (!arst_n) depth_q <= DMAX)
		else $error("comment depth above limit");
	a_line: assert property (@(posedge clk) disable iff (!arst_n) line_q != '0)
		else $error("line counter zero");
	a_eoi: assert property (@(posedge clk) disable iff (!arst_n)
		$past(take) && $past(end_of_input) |-> state_q == S_IDLE)
		else $error("scanner not idle after end of input");
`endif
endmodule

@@ rtl/core/sbt_queue.sv @@
// back part: descriptor queue that serializes bursts of up to three descriptors
module sbt_queue #(
	parameter int DEPTH = sbt_pkg::QueueDepth
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic [1:0]      push_n,
	input  sbt_pkg::token_t d0,
	input  sbt_pkg::token_t d1,
	input  sbt_pkg::token_t d2,
	output logic            room,
	output logic            out_valid,
	input  logic            out_stall,
	output sbt_pkg::token_t out_tok
);
	import sbt_pkg::*;

	localparam int AW = $clog2(DEPTH);

	token_t          mem_q [DEPTH];
	logic [AW-1:0]   rd_q, wr_q;
	logic [AW:0]     cnt_q;
	logic            pop;
	logic [1:0]      nin;

	assign nin = push ? push_n : 2'd0;
	assign pop = out_valid && !out_stall;
	assign out_valid = cnt_q != '0;
	assign out_tok = mem_q[rd_q];
	assign room = (cnt_q - (AW + 1)'(pop)) <= (AW + 1)'(DEPTH - 3);

	always_ff @(posedge clk) begin
		if (nin > 2'd0) mem_q[wr_q] <= d0;
		if (nin > 2'd1) mem_q[AW'(wr_q + AW'(1))] <= d1;
		if (nin > 2'd2) mem_q[AW'(wr_q + AW'(2))] <= d2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0; wr_q <= '0; cnt_q <= '0;
		end else begin
			wr_q <= wr_q + AW'(nin);
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (AW + 1)'(nin) - (AW + 1)'(pop);
		end
	end

`ifndef SYNTH
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= (AW + 1)'(DEPTH))
		else $error("queue overflow");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("queued transaction lost");
	a_push: assert property (@(posedge clk) disable iff (!arst_n) push |-> room)
		else $error("push without room");
`endif
endmodule

@@ rtl/core/source_byte_tokenizer.sv @@
// top level of the source byte tokenizer
// the scanner is combinational; descriptors are registered in the descriptor queue before they leave
// throughput: one byte per cycle while the four-entry descriptor queue has room for three
// a byte causing several descriptors drains them one per cycle through the queue while out_stall is low
// reset: asynchronous, active low; scanner idle, line and column one, queue empty
module source_byte_tokenizer #(
	parameter int MAX_COMMENT_DEPTH = sbt_pkg::MaxCommentDepth,
	parameter int KEYWORD_BYTES     = sbt_pkg::KeywordBytes,
	parameter int COUNTER_BITS      = sbt_pkg::CounterBits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  source_byte,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  token_kind,
	output logic [15:0] token_length,
	output logic [15:0] start_line,
	output logic [15:0] start_column,
	output logic [2:0]  error_code,
	output logic        last_of_run
);
	import sbt_pkg::*;

	logic       room, take;
	logic [1:0] n;
	token_t     t0, t1, t2, q;

	assign in_stall = !room;
	assign take = in_valid && room;

	sbt_scan #(
		.MAX_COMMENT_DEPTH(MAX_COMMENT_DEPTH),
		.KEYWORD_BYTES(KEYWORD_BYTES),
		.COUNTER_BITS(COUNTER_BITS)
	) u_scan (
		.clk, .arst_n, .take, .source_byte, .end_of_input,
		.tok_n(n), .tok0(t0), .tok1(t1), .tok2(t2)
	);

	sbt_queue u_queue (
		.clk, .arst_n, .push(take), .push_n(n), .d0(t0), .d1(t1), .d2(t2),
		.room, .out_valid, .out_stall, .out_tok(q)
	);

	assign token_kind   = q.kind;
	assign token_length = q.length;
	assign start_line   = q.line;
	assign start_column = q.column;
	assign error_code   = q.err;
	assign last_of_run  = q.last;
endmodule

@@ bench/tb.sv @@
// self-checking testbench for the source byte tokenizer
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sbt_pkg::*;

	localparam int CntMax = 65535;
	localparam int LenMax = 65535;
	localparam int WatchLimit = 4000;
	localparam int HoldCycles = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  source_byte = 8'h00;
	logic        end_of_input = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [6:0]  token_kind;
	logic [15:0] token_length;
	logic [15:0] start_line;
	logic [15:0] start_column;
	logic [2:0]  error_code;
	logic        last_of_run;

	source_byte_tokenizer u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.source_byte(source_byte), .end_of_input(end_of_input),
		.out_valid(out_valid), .out_stall(out_stall),
		.token_kind(token_kind), .token_length(token_length),
		.start_line(start_line), .start_column(start_column),
		.error_code(error_code), .last_of_run(last_of_run)
	);

	always #4 clk = ~clk;

	// scanner copy
	scan_t      lex_state;
	logic [7:0] word_buf [8];
	int         tok_len;
	int         cur_line, cur_col, tok_line, tok_col;
	int         nest_depth;
	logic [7:0] held_op;
	int         utf_left;
	bit         newline_seen;
	token_t     step_tokens[$];
	token_t     token_q[$];

	string keywords[18] = '{"if", "ef", "else", "for", "break", "continue", "func", "return",
		"error", "deal", "case", "type", "in", "ot", "include", "module", "default", "switch"};

	bit idle_on = 1'b0;
	int hold_req = 0;
	int hold_done = 0;
	int hold_left = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	logic [7:0] src_q[$];

	function automatic bit letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic bit digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit hex_digit(logic [7:0] c);
		return digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [6:0] op_single(logic [7:0] c);
		case (c)
			"(": return 26; ")": return 27; "&": return 28; "!": return 31;
			"%": return 33; ".": return 35; ",": return 36; "+": return 37;
			"-": return 40; "*": return 43; "=": return 45; "<": return 47;
			">": return 50; ":": return 53; "/": return 54; "{": return 56;
			"[": return 57; "]": return 58; "?": return 59; "^": return 60;
			"}": return 62; "|": return 63; "~": return 66;
			default: return K_NONE;
		endcase
	endfunction

	function automatic bit op_pairable(logic [7:0] c);
		return c inside {"&", "!", "%", "+", "-", "*", "=", "<", ">", "/", "^", "|"};
	endfunction

	function automatic logic [6:0] op_pair(logic [7:0] p, logic [7:0] c);
		case ({p, c})
			{"&", "&"}: return 29; {"&", "="}: return 30; {"!", "="}: return 32;
			{"%", "="}: return 34; {"+", "+"}: return 38; {"+", "="}: return 39;
			{"-", "-"}: return 41; {"-", "="}: return 42; {"*", "="}: return 44;
			{"=", "="}: return 46; {"<", "="}: return 48; {"<", "<"}: return 49;
			{">", "="}: return 51; {">", ">"}: return 52; {"/", "="}: return 55;
			{"^", "="}: return 61; {"|", "|"}: return 64; {"|", "="}: return 65;
			default: return K_NONE;
		endcase
	endfunction

	function void emit_token(logic [6:0] k, logic [2:0] e);
		token_t t;
		if (step_tokens.size() >= 3) return;
		t.kind = k;
		t.length = tok_len[15:0];
		t.line = tok_line[15:0];
		t.column = tok_col[15:0];
		t.err = e;
		t.last = 1'b0;
		step_tokens.push_back(t);
	endfunction

	function void begin_token(logic [7:0] c);
		tok_line = cur_line;
		tok_col = cur_col;
		tok_len = 1;
		foreach (word_buf[i]) word_buf[i] = 8'h00;
		word_buf[0] = c;
	endfunction

	function void take_byte(logic [7:0] c);
		if (tok_len < 8) word_buf[tok_len] = c;
		if (tok_len < LenMax) tok_len++;
	endfunction

	function logic [6:0] word_kind();
		bit same;
		for (int i = 0; i < 18; i++) begin
			if (tok_len == keywords[i].len()) begin
				same = 1'b1;
				for (int j = 0; j < tok_len; j++)
					if (word_buf[j] != keywords[i][j]) same = 1'b0;
				if (same) return 7'(i + 1);
			end
		end
		return K_IDENT;
	endfunction

	function void emit_held_op();
		if (op_single(held_op) == K_NONE) emit_token(K_IDENT, E_UNKNOWN);
		else emit_token(op_single(held_op), E_NONE);
	endfunction

	function void start_from_idle(logic [7:0] c);
		if (c == " " || c == "\t") return;
		begin_token(c);
		if (c == "\r" || c == "\n") begin
			emit_token(K_NL, E_NONE);
			if (cur_line < CntMax) cur_line++;
			newline_seen = 1'b1;
		end else if (letter(c)) lex_state = S_IDENT;
		else if (c == "0") lex_state = S_ZERO;
		else if (digit(c)) lex_state = S_DEC;
		else if (c == "\"") lex_state = S_STR;
		else if (c == "'") lex_state = S_CHR0;
		else if (op_pairable(c)) begin
			held_op = c;
			lex_state = S_OPP;
		end else if (op_single(c) != K_NONE) emit_token(op_single(c), E_NONE);
		else emit_token(K_IDENT, E_UNKNOWN);
	endfunction

	function bit close_before(logic [6:0] k, logic [2:0] e);
		emit_token(k, e);
		lex_state = S_IDLE;
		return 1'b1;
	endfunction

	// returns 1 when the byte must be looked at again from idle
	function bit scan_byte(logic [7:0] c);
		logic [6:0] k;
		case (lex_state)
			S_IDENT: begin
				if (letter(c) || digit(c)) take_byte(c);
				else return close_before(word_kind(), E_NONE);
			end
			S_ZERO: begin
				if (c == "x" || c == "X") lex_state = S_HEX;
				else if (c == "b" || c == "B") lex_state = S_BIN;
				else if (c == "o" || c == "O") lex_state = S_OCT;
				else if (c == "d" || c == "D") lex_state = S_DECP;
				else return close_before(K_INT, E_NONE);
				take_byte(c);
			end
			S_DEC: begin
				if (c == ".") lex_state = S_FRAC;
				else if (c == "e" || c == "E") lex_state = S_EXPI0;
				else if (!digit(c)) return close_before(K_INT, E_NONE);
				take_byte(c);
			end
			S_FRAC: begin
				if (c == "e" || c == "E") lex_state = S_EXPF0;
				else if (!digit(c)) return close_before(K_FLT, E_NONE);
				take_byte(c);
			end
			S_EXPI0, S_EXPF0: begin
				if (c == "+" || c == "-" || digit(c)) begin
					take_byte(c);
					lex_state = (lex_state == S_EXPI0) ? S_EXPI : S_EXPF;
				end else return close_before(lex_state == S_EXPI0 ? K_INT : K_FLT, E_NONE);
			end
			S_EXPI, S_EXPF: begin
				if (digit(c)) take_byte(c);
				else return close_before(lex_state == S_EXPI ? K_INT : K_FLT, E_NONE);
			end
			S_HEX: if (hex_digit(c)) take_byte(c); else return close_before(K_INT, E_NONE);
			S_BIN: if (c == "0" || c == "1") take_byte(c); else return close_before(K_INT, E_NONE);
			S_OCT: if (c >= "0" && c <= "7") take_byte(c); else return close_before(K_INT, E_NONE);
			S_DECP: if (digit(c)) take_byte(c); else return close_before(K_INT, E_NONE);
			S_STR: begin
				take_byte(c);
				if (c == "\"") begin
					emit_token(K_STR, E_NONE);
					lex_state = S_IDLE;
				end
			end
			S_CHR0: begin
				if (c == "\\") begin
					take_byte(c);
					lex_state = S_CHRE;
					return 1'b0;
				end
				if (c < 8'h80) lex_state = S_CHRC;
				else if ((c & 8'hE0) == 8'hC0) begin utf_left = 1; lex_state = S_CHRU; end
				else if ((c & 8'hF0) == 8'hE0) begin utf_left = 2; lex_state = S_CHRU; end
				else if ((c & 8'hF8) == 8'hF0) begin utf_left = 3; lex_state = S_CHRU; end
				else return close_before(K_CHR, E_UTF8);
				take_byte(c);
			end
			S_CHRU: begin
				take_byte(c);
				if (utf_left > 0) utf_left--;
				if (utf_left == 0) lex_state = S_CHRC;
			end
			S_CHRE: begin
				if (c inside {"a", "b", "f", "n", "r", "v", "\\", "'", "\"", "0"}) begin
					take_byte(c);
					lex_state = S_CHRC;
				end else return close_before(K_CHR, E_ESCAPE);
			end
			S_CHRC: begin
				if (c == "'") begin
					take_byte(c);
					emit_token(K_CHR, E_NONE);
					lex_state = S_IDLE;
				end else return close_before(K_CHR, E_UNCLOSED);
			end
			S_OPP: begin
				k = op_pair(held_op, c);
				if (held_op == "/" && c == "/") begin
					take_byte(c);
					lex_state = S_LCMT;
				end else if (held_op == "/" && c == "*") begin
					take_byte(c);
					nest_depth = 0;
					lex_state = S_BCMT;
				end else if (k != K_NONE) begin
					take_byte(c);
					emit_token(k, E_NONE);
					lex_state = S_IDLE;
				end else begin
					emit_held_op();
					lex_state = S_IDLE;
					return 1'b1;
				end
			end
			S_LCMT: if (c == "\r" || c == "\n") return close_before(K_LCMT, E_NONE); else take_byte(c);
			S_BCMT, S_BSTAR, S_BSLASH: begin
				take_byte(c);
				if (lex_state == S_BSTAR && c == "/") begin
					if (nest_depth == 0) begin
						emit_token(K_BCMT, E_NONE);
						lex_state = S_IDLE;
						return 1'b0;
					end
					nest_depth--;
					lex_state = S_BSLASH;
				end else if (lex_state == S_BSLASH && c == "*") begin
					if (nest_depth < MaxCommentDepth) nest_depth++;
					lex_state = S_BCMT;
				end else if (c == "*") lex_state = S_BSTAR;
				else if (c == "/") lex_state = S_BSLASH;
				else lex_state = S_BCMT;
			end
			default: begin
				lex_state = S_IDLE;
				start_from_idle(c);
			end
		endcase
		return 1'b0;
	endfunction

	function void flush_token();
		case (lex_state)
			S_IDLE: ;
			S_IDENT: emit_token(word_kind(), E_NONE);
			S_FRAC, S_EXPF0, S_EXPF: emit_token(K_FLT, E_NONE);
			S_ZERO, S_DEC, S_EXPI0, S_EXPI, S_HEX, S_BIN, S_OCT, S_DECP:
				emit_token(K_INT, E_NONE);
			S_STR: emit_token(K_STR, E_NONE);
			S_CHR0, S_CHRU, S_CHRE, S_CHRC: emit_token(K_CHR, E_UNCLOSED);
			S_OPP: emit_held_op();
			S_LCMT: emit_token(K_LCMT, E_NONE);
			default: emit_token(K_BCMT, E_NONE);
		endcase
		lex_state = S_IDLE;
		nest_depth = 0;
		held_op = 8'h00;
		utf_left = 0;
	endfunction

	function void predict_tokens(logic [7:0] c, bit eoi);
		step_tokens.delete();
		newline_seen = 1'b0;
		if (scan_byte(c)) void'(scan_byte(c));
		if (newline_seen) cur_col = 1;
		else if (cur_col < CntMax) cur_col++;
		if (eoi) flush_token();
		if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
		foreach (step_tokens[i]) token_q.push_back(step_tokens[i]);
	endfunction

	task automatic send_byte(logic [7:0] c, bit eoi);
		bit taken;
		while (idle_on && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		source_byte <= c;
		end_of_input <= eoi;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		predict_tokens(c, eoi);
	endtask

	task automatic send_text(string s, bit eoi_last);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], eoi_last && i == s.len() - 1);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		wait (token_q.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	// output side: stall generation and descriptor checks
	always @(posedge clk) begin
		if (hold_req != hold_done) begin
			hold_done <= hold_req;
			hold_left <= HoldCycles;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else out_stall <= idle_on && $urandom_range(99) < 31;
	end

	always @(negedge clk) begin
		token_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (token_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected descriptor kind %0d", token_kind);
			end else begin
				want = token_q.pop_front();
				if (token_kind !== want.kind || token_length !== want.length ||
						start_line !== want.line || start_column !== want.column ||
						error_code !== want.err || last_of_run !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: want k%0d len%0d ln%0d col%0d e%0d l%0d, got k%0d len%0d ln%0d col%0d e%0d l%0d",
							want.kind, want.length, want.line, want.column, want.err, want.last,
							token_kind, token_length, start_line, start_column, error_code,
							last_of_run);
				end
			end
		end
	end

	always @(negedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WatchLimit) begin
			$display("source_byte_tokenizer regression: fail");
			$finish;
		end
	end

	task automatic test_words();
		send_text("if ef else for break continue func return error deal case type ", 1'b0);
		send_text("in ot include module default switch _x9 continues Ab\n", 1'b0);
	endtask

	task automatic test_numbers();
		send_text("0 0x 0b 0o 0d 0xfA9 0B102 0o789 0D42 123 1.5 2e 7e+3 3.E-1 4.25e9z\n", 1'b0);
	endtask

	task automatic test_literals();
		send_text("\"ab\nc\" 'a' '\\n' '\\q' 'ab '", 1'b0);
		send_byte("'", 1'b0);
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b0);
		send_byte(8'hAC, 1'b0);
		send_text("' '", 1'b0);
		send_byte(8'hFF, 1'b0);
		send_text("'", 1'b0);
		send_byte(8'h90, 1'b0);
		send_text("\r\n", 1'b0);
	endtask

	task automatic test_operators();
		send_text("()&&&=!=!%=%.,+++=+---=-**===<=<<<>=>>>:/=/{[]?^=^}|||=|~\n", 1'b0);
		send_text(";#@$\t// note */\r/* a /* b */ c */ x /*/**/*/\n", 1'b0);
	endtask

	task automatic test_end_of_input();
		send_text("abc", 1'b1);
		send_text("'x", 1'b1);
		send_text("/* open", 1'b1);
		send_text("<", 1'b1);
		send_text("1.", 1'b1);
		send_text("\n", 1'b1);
	endtask

	function automatic logic [7:0] pick(string s);
		return s[$urandom_range(s.len() - 1)];
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++) src_q.push_back(s[i]);
	endfunction

	function automatic void add_fragment();
		string alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
		string ops = "()&!%.,+-*=<>:/{[]?^}|~";
		int n;
		case ($urandom_range(11))
			0: add_text(keywords[$urandom_range(17)]);
			1: begin
				src_q.push_back(pick("abcxyzQ_"));
				n = $urandom_range(9);
				repeat (n) src_q.push_back(pick(alnum));
			end
			2: begin
				add_text($urandom_range(1) ? "0" : "7");
				src_q.push_back(pick("xXbBoOdD05.e"));
				repeat ($urandom_range(4)) src_q.push_back(pick("0123456789abfE+-."));
			end
			3: begin
				src_q.push_back("\"");
				repeat ($urandom_range(6)) src_q.push_back(8'($urandom_range(255)));
				if ($urandom_range(5) != 0) src_q.push_back("\"");
			end
			4: begin
				src_q.push_back("'");
				case ($urandom_range(5))
					0: src_q.push_back(pick("\\"));
					1: begin
						src_q.push_back("\\");
						src_q.push_back($urandom_range(1) ? pick("abfnrv\\'\"0") : pick("xq7'"));
					end
					2: begin
						src_q.push_back(8'($urandom_range(8'hC0, 8'hF7)));
						repeat ($urandom_range(3))
							src_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
					end
					3: src_q.push_back($urandom_range(1) ? 8'($urandom_range(8'h80, 8'hBF))
						: 8'($urandom_range(8'hF8, 8'hFF)));
					default: src_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
				endcase
				if ($urandom_range(4) != 0) src_q.push_back("'");
			end
			5: begin
				src_q.push_back(pick(ops));
				if ($urandom_range(1)) src_q.push_back(pick("=&|+-<>/*"));
			end
			6: begin
				add_text("//");
				repeat ($urandom_range(5)) src_q.push_back(pick("a */x"));
				src_q.push_back(pick("\r\n"));
			end
			7: begin
				add_text("/*");
				n = $urandom_range(20);
				repeat (n) src_q.push_back(pick("/**/ab"));
				add_text("*/");
			end
			8: src_q.push_back(8'($urandom_range(255)));
			9: src_q.push_back(pick("\r\n"));
			default: src_q.push_back(pick(" \t"));
		endcase
	endfunction

	task automatic test_random(int count);
		logic [7:0] c;
		int sent;
		sent = 0;
		while (sent < count) begin
			src_q.delete();
			add_fragment();
			add_fragment();
			src_q.push_back(pick(" \t\n"));
			while (src_q.size() > 0 && sent < count) begin
				c = src_q.pop_front();
				if (sent == 60) idle_on = 1'b1;
				send_byte(c, $urandom_range(39) == 0);
				sent++;
			end
		end
	endtask

	task automatic test_backpressure();
		hold_req++;
		test_random(30);
		wait_drained();
	endtask

	initial begin
		lex_state = S_IDLE;
		foreach (word_buf[i]) word_buf[i] = 8'h00;
		tok_len = 0;
		cur_line = 1;
		cur_col = 1;
		tok_line = 1;
		tok_col = 1;
		nest_depth = 0;
		held_op = 8'h00;
		utf_left = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_words();
		test_numbers();
		test_literals();
		test_operators();
		test_end_of_input();
		wait_drained();
		test_backpressure();
		idle_on = 1'b1;
		test_random(40);
		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && token_q.size() == 0) begin
			$display("source_byte_tokenizer regression: pass");
		end else begin
			$display("source_byte_tokenizer regression: fail");
		end
		$finish;
	end

endmodule
